// ----- hdl/mss_pkg.sv -----
// Shared types, constants and helpers for the motor step test sequencer.
`timescale 1ns / 1ps

package mss_pkg;

  // Widths of the configuration fields and of the datapath values
  localparam int CNT_W    = 16;
  localparam int STEP_W   = 3;
  localparam int FSP_W    = 17;
  localparam int VOLT_W   = 8;
  localparam int STEPS_W  = 48;
  localparam int POS_W    = 32;
  localparam int CMP_W    = 16;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;
  // dividend of the compare division: full_scale_period * voltage
  localparam int DIV_W    = FSP_W + VOLT_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CPR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULLSCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAXV      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VSTEPS    = 3'd7;

  // Reset values of the registers
  localparam logic [CNT_W-1:0]   SAMPLES_RST   = 16'd1000;
  localparam logic [CNT_W-1:0]   STOP_RST      = 16'd500;
  localparam logic [STEP_W-1:0]  CURVES_RST    = 3'd6;
  localparam logic [CNT_W-1:0]   CPR_RST       = 16'd4096;
  localparam logic [CNT_W-1:0]   LAP_RST       = 16'd2048;
  localparam logic [FSP_W-1:0]   FULLSCALE_RST = 17'd2100;
  localparam logic [VOLT_W-1:0]  MAXV_RST      = 8'd12;
  localparam logic [STEPS_W-1:0] VSTEPS_RST    = 48'h0C0806040201;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISHED = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]   samples_per_curve;
    logic [CNT_W-1:0]   stop_sample;
    logic [STEP_W-1:0]  curve_count;
    logic [CNT_W-1:0]   counts_per_rev;
    logic [CNT_W-1:0]   lap_threshold;
    logic [FSP_W-1:0]   full_scale_period;
    logic [VOLT_W-1:0]  full_scale_volt;
    logic [STEPS_W-1:0] voltage_steps;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_enc;     // latch the tick's encoder count
    logic sample;       // count sample, lap check, stop-sample check
    logic pos_mul;      // turns times counts per revolution
    logic emit_sample;  // load a position word into the output register
    logic step_setup;   // pick voltage, voltage product, restart counters
    logic div_start;    // launch the compare division
    logic cmp_finish;   // scale and clamp the quotient into the compare
    logic emit_step;    // load a new-step word
    logic emit_done;    // load the finished word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_pending; // sample counter below samples_per_curve
    logic step_avail;     // another table voltage is left to run
    logic div_done;
    logic out_free;       // output register can take a word this cycle
  } stat_t;

  // Byte of the voltage table at a step index; indexes past the table read 0
  function automatic logic [VOLT_W-1:0] step_volt(input logic [STEPS_W-1:0] tbl,
                                                  input logic [STEP_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    v = '0;
    case (idx)
      3'd0: v = tbl[7:0];
      3'd1: v = tbl[15:8];
      3'd2: v = tbl[23:16];
      3'd3: v = tbl[31:24];
      3'd4: v = tbl[39:32];
      3'd5: v = tbl[47:40];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/mss_div.sv -----
// Restoring divider, one quotient bit per cycle, for the PWM compare value.
`timescale 1ns / 1ps

module mss_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mss_pkg::DIV_W-1:0]        dividend,
  input  logic [mss_pkg::VOLT_W-1:0]       divisor,
  output logic                             done,
  output logic [mss_pkg::DIV_W-1:0]        quotient
);

  localparam int ITER_W = $clog2(mss_pkg::DIV_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(mss_pkg::DIV_W - 1);

  logic                          busy;
  logic [ITER_W-1:0]             iter;
  logic [mss_pkg::VOLT_W-1:0]    rem;
  logic [mss_pkg::DIV_W-1:0]     quo;

  logic [mss_pkg::VOLT_W:0]      trial;
  logic [mss_pkg::VOLT_W:0]      diff;
  logic                          fits;

  assign trial = {rem, quo[mss_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[mss_pkg::VOLT_W-1:0] : trial[mss_pkg::VOLT_W-1:0];
      quo <= {quo[mss_pkg::DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ----- hdl/mss_datapath.sv -----
// Datapath: sample and lap counters, position multiply, compare scaling, output register.
`timescale 1ns / 1ps

module mss_datapath #(
  parameter int STEP_SLOTS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mss_pkg::cfg_t                      cfg,
  input  mss_pkg::cmd_t                      cmd,
  output mss_pkg::stat_t                     stat,
  input  logic [mss_pkg::CNT_W-1:0]          enc_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mss_pkg::KIND_W-1:0]         out_kind,
  output logic [mss_pkg::POS_W-1:0]          out_pos,
  output logic [mss_pkg::VOLT_W-1:0]         out_volt,
  output logic [mss_pkg::CMP_W-1:0]          out_cmp,
  output logic                               out_clr,
  output logic                               out_last
);

  localparam logic [mss_pkg::STEP_W-1:0] SLOTS = mss_pkg::STEP_W'(STEP_SLOTS);

  // run state
  logic [mss_pkg::CNT_W-1:0]  sample_counter;
  logic [mss_pkg::STEP_W-1:0] step_index;
  logic [mss_pkg::CNT_W-1:0]  previous_count;
  logic [mss_pkg::CNT_W-1:0]  turn_count;
  logic [mss_pkg::CMP_W-1:0]  compare_value;

  // working registers
  logic [mss_pkg::CNT_W-1:0]  enc;
  logic [mss_pkg::POS_W-1:0]  turn_prod;
  logic [mss_pkg::VOLT_W-1:0] volt;
  logic [mss_pkg::DIV_W-1:0]  volt_prod;

  logic [mss_pkg::CNT_W-1:0]  counter_next;
  logic                       lap;
  logic [mss_pkg::STEP_W-1:0] curves;
  logic                       div_done;
  logic [mss_pkg::DIV_W-1:0]  quotient;
  logic [mss_pkg::DIV_W-1:0]  q_minus;
  logic [mss_pkg::FSP_W-1:0]  ceil_wide;
  logic [mss_pkg::CMP_W-1:0]  ceil_cmp;
  logic [mss_pkg::CMP_W-1:0]  cmp_scaled;
  logic                       out_free;

  assign counter_next = sample_counter + 1'b1;
  assign lap = ({1'b0, enc} + {1'b0, cfg.lap_threshold}) < {1'b0, previous_count};
  assign curves = (cfg.curve_count > SLOTS) ? SLOTS : cfg.curve_count;

  // compare = min(q - 1, full_scale - 1, 0xFFFF), with the zero cases
  assign q_minus   = (quotient == '0) ? '0 : quotient - 1'b1;
  assign ceil_wide = cfg.full_scale_period - 1'b1;
  assign ceil_cmp  = ceil_wide[mss_pkg::FSP_W-1] ? '1 : ceil_wide[mss_pkg::CMP_W-1:0];

  always_comb begin
    if (volt == '0 || cfg.full_scale_period == '0) begin
      cmp_scaled = '0;
    end else if (cfg.full_scale_volt == '0) begin
      cmp_scaled = ceil_cmp;
    end else if (q_minus > {{(mss_pkg::DIV_W-mss_pkg::CMP_W){1'b0}}, ceil_cmp}) begin
      cmp_scaled = ceil_cmp;
    end else begin
      cmp_scaled = q_minus[mss_pkg::CMP_W-1:0];
    end
  end

  mss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (volt_prod),
    .divisor  (cfg.full_scale_volt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !out_valid || out_ready;

  assign stat.sample_pending = sample_counter < cfg.samples_per_curve;
  assign stat.step_avail     = step_index < curves;
  assign stat.div_done       = div_done;
  assign stat.out_free       = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= mss_pkg::SAMPLES_RST;
      step_index     <= '0;
      previous_count <= '0;
      turn_count     <= '0;
      compare_value  <= '0;
    end else begin
      if (cmd.sample) begin
        sample_counter <= counter_next;
        previous_count <= enc;
        if (lap) begin
          turn_count <= turn_count + 1'b1;
        end
        if (counter_next == cfg.stop_sample) begin
          compare_value <= '0;
        end
      end
      if (cmd.step_setup) begin
        step_index     <= step_index + 1'b1;
        sample_counter <= '0;
        previous_count <= '0;
        turn_count     <= '0;
      end
      if (cmd.cmp_finish) begin
        compare_value <= cmp_scaled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_enc) begin
      enc <= enc_in;
    end
    if (cmd.pos_mul) begin
      turn_prod <= cfg.counts_per_rev * turn_count;
    end
    if (cmd.step_setup) begin
      volt      <= mss_pkg::step_volt(cfg.voltage_steps, step_index);
      volt_prod <= cfg.full_scale_period *
                   mss_pkg::step_volt(cfg.voltage_steps, step_index);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_step || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample) begin
      out_kind <= mss_pkg::KIND_POSITION;
      out_pos  <= {{(mss_pkg::POS_W-mss_pkg::CNT_W){1'b0}}, enc} + turn_prod;
      out_volt <= '0;
      out_cmp  <= compare_value;
      out_clr  <= 1'b0;
      // a step change or finish word follows when the curve is complete
      out_last <= sample_counter < cfg.samples_per_curve;
    end else if (cmd.emit_step) begin
      out_kind <= mss_pkg::KIND_STEP;
      out_pos  <= '0;
      out_volt <= volt;
      out_cmp  <= compare_value;
      out_clr  <= 1'b1;
      out_last <= 1'b1;
    end else if (cmd.emit_done) begin
      out_kind <= mss_pkg::KIND_FINISHED;
      out_pos  <= '0;
      out_volt <= '0;
      out_cmp  <= compare_value;
      out_clr  <= 1'b0;
      out_last <= 1'b1;
    end
  end

endmodule

// ----- hdl/mss_ctrl.sv -----
// Controller state machine: sequences one tick through sample, step start or finish.
`timescale 1ns / 1ps

module mss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mss_pkg::stat_t stat,
  output mss_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAMPLE,
    S_MUL,
    S_EMIT_SAMPLE,
    S_CHECK,
    S_STEP_SETUP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH,
    S_EMIT_STEP,
    S_EMIT_DONE
  } state_t;

  state_t state;
  logic   done_flag;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:        cmd.load_enc    = accept && !done_flag;
      S_SAMPLE:      cmd.sample      = 1'b1;
      S_MUL:         cmd.pos_mul     = 1'b1;
      S_EMIT_SAMPLE: cmd.emit_sample = stat.out_free;
      S_CHECK:       ;
      S_STEP_SETUP:  cmd.step_setup  = 1'b1;
      S_DIV_GO:      cmd.div_start   = 1'b1;
      S_DIV_WAIT:    ;
      S_FINISH:      cmd.cmp_finish  = 1'b1;
      S_EMIT_STEP:   cmd.emit_step   = stat.out_free;
      S_EMIT_DONE:   cmd.emit_done   = stat.out_free;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // after the finish word ticks are taken and dropped
          if (accept && !done_flag) begin
            state <= stat.sample_pending ? S_SAMPLE : S_CHECK;
          end
        end
        S_SAMPLE:      state <= S_MUL;
        S_MUL:         state <= S_EMIT_SAMPLE;
        S_EMIT_SAMPLE: begin
          if (stat.out_free) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.sample_pending) begin
            state <= S_IDLE;
          end else if (stat.step_avail) begin
            state <= S_STEP_SETUP;
          end else begin
            state <= S_EMIT_DONE;
          end
        end
        S_STEP_SETUP:  state <= S_DIV_GO;
        S_DIV_GO:      state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH:      state <= S_EMIT_STEP;
        S_EMIT_STEP: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT_DONE: begin
          if (stat.out_free) begin
            state     <= S_IDLE;
            done_flag <= 1'b1;
          end
        end
        default:       state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/motor_step_test_sequencer.sv -----
// Top level of the motor step-response test sequencer: register file and unit wiring.
`timescale 1ns / 1ps

// Step-response test sequencer. Each word on the s_ side is one millisecond
// tick with the raw encoder count. While a curve runs every tick gives a
// position word (encoder plus turns times counts_per_rev; a drop of more
// than lap_threshold counts one turn) and the drive compare drops to zero
// at stop_sample. When a curve is complete the next table voltage starts:
// a step word carries the voltage, the new PWM compare
// (full_scale_period * v / full_scale_volt - 1, clamped) and the encoder clear
// request. After curve_count curves (at most STEP_SLOTS) one finished word
// is sent and later ticks are taken without effect until reset.
// A tick gives up to two words; tlast marks the final one of a tick.
// Timing: one tick is taken at a time. A sample runs S_SAMPLE, S_MUL,
// S_EMIT_SAMPLE and S_CHECK; a step start runs S_STEP_SETUP, S_DIV_GO,
// S_DIV_WAIT, S_FINISH and S_EMIT_STEP, its cost set by the
// one-bit-per-cycle compare divider (25 iterations). The finished word
// goes out from S_EMIT_DONE. Words wait in a single output register; a
// word held there by m_tready low while the next one is ready stalls the
// controller. The user must write configuration through cfg_* (always
// ready) only while the block is idle; the block does not enforce it.

module motor_step_test_sequencer #(
  parameter int STEP_SLOTS = 6   // voltage table slots used, 1 to 6
) (
  input  logic                                clk,
  input  logic                                rst,
  // tick input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mss_pkg::IN_DATA_W-1:0]       s_tdata,   // [15:0] encoder_count
  // result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mss_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] position,
                                                         // [39:32] step_voltage,
                                                         // [55:40] drive_compare,
                                                         // [56] clear_encoder, rest 0
  output logic [mss_pkg::KIND_W-1:0]          m_tuser,   // [1:0] kind
  output logic                                m_tlast,   // last word of this tick
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mss_pkg::CFG_DAT_W-1:0]       cfg_data
);

  mss_pkg::cfg_t  cfg;
  mss_pkg::cmd_t  cmd;
  mss_pkg::stat_t stat;

  logic [mss_pkg::POS_W-1:0]  out_pos;
  logic [mss_pkg::VOLT_W-1:0] out_volt;
  logic [mss_pkg::CMP_W-1:0]  out_cmp;
  logic                       out_clr;

  // configuration register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_curve <= mss_pkg::SAMPLES_RST;
      cfg.stop_sample       <= mss_pkg::STOP_RST;
      cfg.curve_count       <= mss_pkg::CURVES_RST;
      cfg.counts_per_rev    <= mss_pkg::CPR_RST;
      cfg.lap_threshold     <= mss_pkg::LAP_RST;
      cfg.full_scale_period <= mss_pkg::FULLSCALE_RST;
      cfg.full_scale_volt   <= mss_pkg::MAXV_RST;
      cfg.voltage_steps     <= mss_pkg::VSTEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mss_pkg::REG_SAMPLES:   cfg.samples_per_curve <= cfg_data[mss_pkg::CNT_W-1:0];
        mss_pkg::REG_STOP:      cfg.stop_sample       <= cfg_data[mss_pkg::CNT_W-1:0];
        mss_pkg::REG_CURVES:    cfg.curve_count       <= cfg_data[mss_pkg::STEP_W-1:0];
        mss_pkg::REG_CPR:       cfg.counts_per_rev    <= cfg_data[mss_pkg::CNT_W-1:0];
        mss_pkg::REG_LAP:       cfg.lap_threshold     <= cfg_data[mss_pkg::CNT_W-1:0];
        mss_pkg::REG_FULLSCALE: cfg.full_scale_period <= cfg_data[mss_pkg::FSP_W-1:0];
        mss_pkg::REG_MAXV:      cfg.full_scale_volt   <= cfg_data[mss_pkg::VOLT_W-1:0];
        mss_pkg::REG_VSTEPS:    cfg.voltage_steps     <= cfg_data[mss_pkg::STEPS_W-1:0];
        default:                ;
      endcase
    end
  end

  mss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mss_datapath #(
    .STEP_SLOTS (STEP_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .enc_in    (s_tdata[mss_pkg::CNT_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_pos   (out_pos),
    .out_volt  (out_volt),
    .out_cmp   (out_cmp),
    .out_clr   (out_clr),
    .out_last  (m_tlast)
  );

  // pack the result word, padded to whole bytes
  assign m_tdata = {7'b0, out_clr, out_cmp, out_volt, out_pos};

endmodule

// ----- tb/sv/tb_motor_step_test_sequencer.sv -----
// Self-checking testbench for the motor step-response test sequencer.
`timescale 1ns / 1ps

// One expected output word, field by field
typedef struct {
  logic [mss_pkg::KIND_W-1:0] kind;
  logic [mss_pkg::POS_W-1:0]  position;
  logic [mss_pkg::VOLT_W-1:0] step_voltage;
  logic [mss_pkg::CMP_W-1:0]  drive_compare;
  logic                       clear_encoder;
  logic                       last;
} seq_word_t;

// Mirror of the sequencer: register copy, curve state and the queue of words still owed
class sequencer_mirror;
  localparam int SLOTS = 6;

  mss_pkg::cfg_t              regs;
  logic [mss_pkg::CNT_W-1:0]  sample_cnt;
  logic [mss_pkg::CNT_W-1:0]  prev_count;
  logic [mss_pkg::CNT_W-1:0]  turns;
  logic [mss_pkg::STEP_W-1:0] step_idx;
  logic [mss_pkg::CMP_W-1:0]  drive_cmp;
  bit                         finished;
  seq_word_t                  pending_words[$];
  int                         errors;

  function new();
    regs.samples_per_curve = mss_pkg::SAMPLES_RST;
    regs.stop_sample       = mss_pkg::STOP_RST;
    regs.curve_count       = mss_pkg::CURVES_RST;
    regs.counts_per_rev    = mss_pkg::CPR_RST;
    regs.lap_threshold     = mss_pkg::LAP_RST;
    regs.full_scale_period = mss_pkg::FULLSCALE_RST;
    regs.full_scale_volt   = mss_pkg::MAXV_RST;
    regs.voltage_steps     = mss_pkg::VSTEPS_RST;
    sample_cnt = mss_pkg::SAMPLES_RST;
    prev_count = '0;
    turns      = '0;
    step_idx   = '0;
    drive_cmp  = '0;
    finished   = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(logic [mss_pkg::CFG_IDX_W-1:0] idx,
                          logic [mss_pkg::CFG_DAT_W-1:0] data);
    case (idx)
      mss_pkg::REG_SAMPLES:   regs.samples_per_curve = data[mss_pkg::CNT_W-1:0];
      mss_pkg::REG_STOP:      regs.stop_sample       = data[mss_pkg::CNT_W-1:0];
      mss_pkg::REG_CURVES:    regs.curve_count       = data[mss_pkg::STEP_W-1:0];
      mss_pkg::REG_CPR:       regs.counts_per_rev    = data[mss_pkg::CNT_W-1:0];
      mss_pkg::REG_LAP:       regs.lap_threshold     = data[mss_pkg::CNT_W-1:0];
      mss_pkg::REG_FULLSCALE: regs.full_scale_period = data[mss_pkg::FSP_W-1:0];
      mss_pkg::REG_MAXV:      regs.full_scale_volt   = data[mss_pkg::VOLT_W-1:0];
      mss_pkg::REG_VSTEPS:    regs.voltage_steps     = data[mss_pkg::STEPS_W-1:0];
      default: ;
    endcase
  endfunction

  // PWM compare for a step voltage: fs*v/max - 1, clamped to fs-1 and 16 bits
  function logic [mss_pkg::CMP_W-1:0] compare_for(logic [mss_pkg::VOLT_W-1:0] v);
    int unsigned fsp, ceiling, q;
    fsp = regs.full_scale_period;
    if (v == 0 || fsp == 0) return '0;
    ceiling = (fsp - 1 > 65535) ? 65535 : fsp - 1;
    if (regs.full_scale_volt == 0) return mss_pkg::CMP_W'(ceiling);
    q = fsp * v / regs.full_scale_volt;
    q = (q == 0) ? 0 : q - 1;
    return (q > ceiling) ? mss_pkg::CMP_W'(ceiling) : mss_pkg::CMP_W'(q);
  endfunction

  function void push_word(logic [mss_pkg::KIND_W-1:0] kind, logic [mss_pkg::POS_W-1:0] pos,
                          logic [mss_pkg::VOLT_W-1:0] volt, logic clr);
    seq_word_t w;
    w.kind          = kind;
    w.position      = pos;
    w.step_voltage  = volt;
    w.drive_compare = drive_cmp;
    w.clear_encoder = clr;
    w.last          = 1'b0;
    pending_words.push_back(w);
  endfunction

  // One accepted tick: sample, then step start or finish
  function void note_tick(logic [mss_pkg::IN_DATA_W-1:0] enc);
    int                          curves;
    int                          before_cnt;
    logic [mss_pkg::STEPS_W-1:0] tbl;
    logic [mss_pkg::VOLT_W-1:0]  v;
    seq_word_t                   w;
    if (finished) return;
    before_cnt = pending_words.size();
    if (sample_cnt < regs.samples_per_curve) begin
      sample_cnt = sample_cnt + 1'b1;
      if (32'(enc) + 32'(regs.lap_threshold) < 32'(prev_count)) turns = turns + 1'b1;
      prev_count = enc;
      if (sample_cnt == regs.stop_sample) drive_cmp = '0;
      push_word(mss_pkg::KIND_POSITION,
                32'(enc) + 32'(regs.counts_per_rev) * 32'(turns), '0, 1'b0);
    end
    if (sample_cnt >= regs.samples_per_curve) begin
      curves = (regs.curve_count > SLOTS) ? SLOTS : int'(regs.curve_count);
      if (int'(step_idx) < curves) begin
        tbl        = regs.voltage_steps;
        v          = tbl[8*step_idx +: 8];
        step_idx   = step_idx + 1'b1;
        sample_cnt = '0;
        prev_count = '0;
        turns      = '0;
        drive_cmp  = compare_for(v);
        push_word(mss_pkg::KIND_STEP, '0, v, 1'b1);
      end else begin
        finished = 1'b1;
        push_word(mss_pkg::KIND_FINISHED, '0, '0, 1'b0);
      end
    end
    if (pending_words.size() > before_cnt) begin
      w = pending_words.pop_back();
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_word(logic [mss_pkg::KIND_W-1:0] kind,
                           logic [mss_pkg::OUT_DATA_W-1:0] data, logic lst);
    seq_word_t e;
    if (pending_words.size() == 0) begin
      $error("unexpected word: kind 0x%0h data 0x%0h", kind, data);
      errors++;
      return;
    end
    e = pending_words.pop_front();
    check_field("kind", 64'(e.kind), 64'(kind));
    check_field("position", 64'(e.position), 64'(data[31:0]));
    check_field("step_voltage", 64'(e.step_voltage), 64'(data[39:32]));
    check_field("drive_compare", 64'(e.drive_compare), 64'(data[55:40]));
    check_field("clear_encoder", 64'(e.clear_encoder), 64'(data[56]));
    check_field("tdata_padding", 64'(0), 64'(data[63:57]));
    check_field("last", 64'(e.last), 64'(lst));
  endfunction
endclass

module tb_motor_step_test_sequencer;

  localparam int STEP_SLOTS   = 6;
  // Pause after the last word before touching registers or ending, so that a
  // step start still in flight has finished.
  localparam int DRAIN_CYCLES = 60;
  // Cycles with no handshake at all before we give up
  localparam int IDLE_LIMIT   = 4000;

  // Hand-picked encoder walk for the lap logic with counts_per_rev = 65535 and
  // a zero threshold: every drop is a lap, every bit toggles both ways.
  localparam logic [15:0] LAP_WALK [20] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 16'h5555, 16'hAAAA,
    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h00FF, 16'hFF00, 16'h0F0F,
    16'hF0F0, 16'h3333, 16'hCCCC, 16'h1234, 16'hFEDC, 16'h0000
  };

  typedef struct {
    logic [mss_pkg::CFG_IDX_W-1:0] idx;
    logic [mss_pkg::CFG_DAT_W-1:0] data;
  } reg_write_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mss_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mss_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic [mss_pkg::KIND_W-1:0]      m_tuser;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index = mss_pkg::REG_SAMPLES;
  logic [mss_pkg::CFG_DAT_W-1:0]   cfg_data = '0;

  sequencer_mirror mirror = new();
  reg_write_t      staged_writes[$];
  int              quiet_cycles = 0;
  int              src_calm = 0;       // stretch of back-to-back ticks left
  int              sink_calm = 0;      // stretch of no back-pressure left
  logic [15:0]     enc_now = '0;       // current simulated encoder reading
  logic [15:0]     cur_cpr = 16'd65535; // counts per turn the walk wraps at

  always #5 clk = ~clk;

  motor_step_test_sequencer #(.STEP_SLOTS(STEP_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Gap length: mostly none or short, a few long, with calm runs of no gaps
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(49) == 0) begin
      calm = $urandom_range(40, 10);
      return 0;
    end
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Next encoder reading: forward rotation wrapping at cpr, some jitter back,
  // some raw noise over all 16 bits
  function automatic logic [15:0] next_count(logic [15:0] cur, logic [15:0] cpr);
    int unsigned r, span;
    r = $urandom_range(99);
    if (r < 8) return 16'($urandom);
    if (r < 13) return cur - 16'($urandom_range(5));
    span = cpr / 8 + 1;
    return 16'((32'(cur) + $urandom_range(span)) % cpr);
  endfunction

  // Sample every handshake at the edge; check words before noting a new tick
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) mirror.check_word(m_tuser, m_tdata, m_tlast);
      if (s_tvalid && s_tready) mirror.note_tick(s_tdata);
      if (cfg_valid && cfg_ready) mirror.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  // Output side back-pressure
  initial begin
    int n;
    forever begin
      n = idle_len(sink_calm);
      if (n == 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: nothing moving for too long means the block hung
  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // One tick word; valid stays up across back-to-back ticks
  task automatic send_tick(logic [mss_pkg::IN_DATA_W-1:0] enc);
    int gap;
    gap = idle_len(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= enc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_ticks(int n);
    repeat (n) begin
      enc_now = next_count(enc_now, cur_cpr);
      send_tick(enc_now);
    end
  endtask

  task automatic stage_reg(logic [mss_pkg::CFG_IDX_W-1:0] idx,
                           logic [mss_pkg::CFG_DAT_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    staged_writes.push_back(w);
    if (idx == mss_pkg::REG_CPR) cur_cpr = data[15:0];
  endtask

  // Stop ticks, let every owed word arrive plus the drain pause, then apply the
  // staged register writes. Also serves as the final drain.
  task automatic settle_and_write();
    reg_write_t w;
    s_tvalid <= 1'b0;
    // wait so the mirror has seen the tick taken at the last edge
    @(posedge clk);
    while (mirror.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (staged_writes.size() != 0) begin
      w = staged_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          len_c, len_d, len_e, len_f, split_e;
    logic [15:0] cpr_pick;
    logic [7:0]  mv5, mv6, v3, v4, v5;
    logic [47:0] vtable;

    // Table plan, one byte per step:
    //   1: zero volts -> compare 0
    //   2: 255 with full-scale volts 0 and full scale 65536 -> 16-bit ceiling
    //   3: anything, full scale 0 -> compare 0
    //   4: small v, full scale 3, max 255 -> quotient 0, no underflow
    //   5: ordinary scaling
    //   6: v at or above max -> clamps at full scale - 1
    mv5 = 8'($urandom_range(255, 1));
    v4  = 8'($urandom_range(mv5));
    v3  = 8'($urandom_range(84, 1));
    mv6 = 8'($urandom_range(20, 1));
    v5  = 8'($urandom_range(255, mv6));
    vtable = {v5, v4, v3, 8'($urandom), 8'hFF, 8'h00};
    len_c = $urandom_range(140, 120);
    len_d = $urandom_range(140, 120);
    len_e = $urandom_range(140, 120);
    len_f = $urandom_range(140, 120);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-sample curves, 7 curves (more than the table holds)
    stage_reg(mss_pkg::REG_SAMPLES, 48'd1);
    stage_reg(mss_pkg::REG_STOP, 48'd1);
    stage_reg(mss_pkg::REG_CURVES, 48'd7);
    stage_reg(mss_pkg::REG_CPR, 48'd65535);
    stage_reg(mss_pkg::REG_LAP, 48'd0);
    stage_reg(mss_pkg::REG_FULLSCALE, 48'h10000);
    stage_reg(mss_pkg::REG_MAXV, 48'd0);
    stage_reg(mss_pkg::REG_VSTEPS, vtable);
    settle_and_write();
    // counter still at its reset value: first tick only starts step 1
    send_tick(16'h0000);
    // one sample hitting the stop sample, then step 2 in the same tick
    send_tick(16'hFFFF);

    // Directed lap walk; stop sample 0 is never reached so the drive holds
    stage_reg(mss_pkg::REG_SAMPLES, 48'd20);
    stage_reg(mss_pkg::REG_STOP, 48'd0);
    stage_reg(mss_pkg::REG_FULLSCALE, 48'd0);
    settle_and_write();
    foreach (LAP_WALK[i]) send_tick(LAP_WALK[i]);

    // Random curve with a realistic encoder; ends on step 4
    cpr_pick = 16'($urandom_range(65535, 2));
    stage_reg(mss_pkg::REG_SAMPLES, 48'(len_c));
    stage_reg(mss_pkg::REG_STOP, 48'($urandom_range(len_c, 1)));
    stage_reg(mss_pkg::REG_CPR, 48'(cpr_pick));
    stage_reg(mss_pkg::REG_LAP, 48'(cpr_pick / 2));
    stage_reg(mss_pkg::REG_FULLSCALE, 48'd3);
    stage_reg(mss_pkg::REG_MAXV, 48'd255);
    settle_and_write();
    enc_now = '0;
    run_ticks(len_c);

    // Longest curve with a threshold that never sees a lap; then samples per
    // curve drops to 0 below the running count, so the next tick only starts step 5
    cpr_pick = 16'($urandom_range(65535, 2));
    stage_reg(mss_pkg::REG_SAMPLES, 48'd65535);
    stage_reg(mss_pkg::REG_STOP, 48'd65535);
    stage_reg(mss_pkg::REG_CPR, 48'(cpr_pick));
    stage_reg(mss_pkg::REG_LAP, 48'd65535);
    settle_and_write();
    run_ticks(len_d);
    stage_reg(mss_pkg::REG_SAMPLES, 48'd0);
    stage_reg(mss_pkg::REG_FULLSCALE, 48'($urandom_range(65536, 1000)));
    stage_reg(mss_pkg::REG_MAXV, 48'(mv5));
    settle_and_write();
    run_ticks(1);

    // Curve with registers changed halfway: one count per turn in the second half
    cpr_pick = 16'($urandom_range(65535, 2));
    stage_reg(mss_pkg::REG_SAMPLES, 48'(len_e));
    stage_reg(mss_pkg::REG_STOP, 48'($urandom_range(len_e + 10, 1)));
    stage_reg(mss_pkg::REG_CPR, 48'(cpr_pick));
    stage_reg(mss_pkg::REG_LAP, 48'(cpr_pick / 2));
    settle_and_write();
    split_e = $urandom_range(len_e - 20, 20);
    run_ticks(split_e);
    stage_reg(mss_pkg::REG_CPR, 48'd1);
    stage_reg(mss_pkg::REG_LAP, 48'($urandom_range(65535)));
    stage_reg(mss_pkg::REG_FULLSCALE, 48'($urandom_range(131071, 1)));
    stage_reg(mss_pkg::REG_MAXV, 48'(mv6));
    settle_and_write();
    run_ticks(len_e - split_e);

    // Last curve; with 7 curves set (read as 6) its end gives the finished word
    cpr_pick = 16'($urandom_range(65535, 2));
    stage_reg(mss_pkg::REG_SAMPLES, 48'(len_f));
    stage_reg(mss_pkg::REG_STOP, 48'($urandom_range(len_f, 1)));
    stage_reg(mss_pkg::REG_CPR, 48'(cpr_pick));
    stage_reg(mss_pkg::REG_LAP, 48'(cpr_pick / 2));
    settle_and_write();
    run_ticks(len_f);

    // Finished: later ticks and writes must stay silent
    stage_reg(mss_pkg::REG_CURVES, 48'd0);
    stage_reg(mss_pkg::REG_SAMPLES, 48'd1);
    settle_and_write();
    run_ticks(8);

    settle_and_write();
    if (mirror.errors == 0 && mirror.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mss_pkg.sv
hdl/mss_div.sv
hdl/mss_datapath.sv
hdl/mss_ctrl.sv
hdl/motor_step_test_sequencer.sv
tb/sv/tb_motor_step_test_sequencer.sv
